[rtl/core/ptd_pkg.sv]
// shared types, codes and helper function of the periodic task dispatcher
package ptd_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_ADD    = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  // scheduler phase held between run beats
  typedef enum logic [1:0] {
    PH_INIT     = 2'd0,
    PH_SCAN     = 2'd1,
    PH_DISPATCH = 2'd2
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_EXISTS   = 3'd2,
    STAT_NO_TASK  = 3'd3,
    STAT_MISMATCH = 3'd4
  } status_t;

  // phase reported by a run beat
  typedef enum logic [1:0] {
    PD_NONE     = 2'd0,
    PD_INIT     = 2'd1,
    PD_SCAN     = 2'd2,
    PD_DISPATCH = 2'd3
  } pdone_t;

  // dispatch timeliness
  typedef enum logic [1:0] {
    TL_ON_TIME = 2'd0,
    TL_DELAYED = 2'd1,
    TL_MISSED  = 2'd2
  } tl_t;

  localparam int GROUP_BITS = 32;
  localparam int ID_BITS    = 6;

  // one result beat
  typedef struct packed {
    status_t              status;
    pdone_t               phase_done;
    logic                 dispatched;
    logic [ID_BITS-1:0]   id;
    logic [15:0]          handle;
    tl_t                  tl;
  } res_t;

  // index of the lowest set bit of a group word
  function automatic logic [4:0] lsb32(input logic [31:0] v);
    logic [31:0] iso;
    logic [4:0]  idx;
    iso    = v & (~v + 32'd1);
    idx[4] = |(iso & 32'hFFFF0000);
    idx[3] = |(iso & 32'hFF00FF00);
    idx[2] = |(iso & 32'hF0F0F0F0);
    idx[1] = |(iso & 32'hCCCCCCCC);
    idx[0] = |(iso & 32'hAAAAAAAA);
    return idx;
  endfunction

endpackage

[rtl/core/ptd_ram.sv]
// generic single-write, single-read ram with registered read data
module ptd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ptd_slot_eval.sv]
// elapsed-time test, timeliness grading and start advance for one slot
module ptd_slot_eval
  import ptd_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] tick,
  input  logic [TICK_BITS-1:0] start,
  input  logic [15:0]          period,
  output logic                 due,
  output tl_t                  tl,
  output logic [TICK_BITS-1:0] start_adv
);

  logic [TICK_BITS-1:0] elapsed;
  logic [TICK_BITS-1:0] per_ext;
  logic [TICK_BITS-1:0] half_ext;
  logic                 half;

  // wrapping elapsed time against full and half period
  assign elapsed   = tick - start;
  assign per_ext   = TICK_BITS'(period);
  assign half_ext  = TICK_BITS'(period >> 1);
  assign due       = elapsed >= per_ext;
  assign half      = elapsed >= half_ext;
  assign start_adv = start + per_ext;

  // grade
  always_comb begin
    if (due) begin
      tl = TL_MISSED;
    end else if (half) begin
      tl = TL_DELAYED;
    end else begin
      tl = TL_ON_TIME;
    end
  end

endmodule

[rtl/core/periodic_task_dispatcher.sv]
// periodic task dispatcher: slot table in ram, sequencer for scan and dispatch
//
// usage: every input beat (in_valid/in_ready) gives exactly one result beat
// (out_valid/out_ready). mode tick advances the tick counter, mode run steps
// the scheduler (init, then scan and dispatch in turn), add and delete edit
// the slot table and report a status code.
// slot period, start and handle live in one ram with a registered read; the
// enable and active bits are flip-flops.
// tick, add, init and rejected edits go straight to the result state;
// delete first reads the slot from the ram and compares its handle; a
// scan reads and writes back one slot per cycle through the ram; a
// dispatch searches one 32-slot group of active bits per cycle and
// then reads the chosen slot. one item is in work at a time.
// reset clears the tick counter, the phase and all enable and active bits;
// ram contents only matter once a slot is added, so no clearing pass runs.
// a stalled receiver holds the result in the output register; a finished
// item waits for that register, and input opens the cycle after it moves in.
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int GROUPS    = 2,
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_task_handle,
  input  logic [15:0] in_period_ticks,
  input  logic [15:0] in_start_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_phase_done,
  output logic        out_dispatched,
  output logic [5:0]  out_dispatched_id,
  output logic [15:0] out_dispatched_handle,
  output logic [1:0]  out_timeliness
);

  localparam int SLOTS = GROUPS * GROUP_BITS;
  localparam int SW    = $clog2(SLOTS);
  localparam int MW    = TICK_BITS + 32;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SRCH = 6'b000100,
    S_DISP = 6'b001000,
    S_DEL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [SLOTS-1:0]     enabled_r, enabled_nxt;
  logic [SLOTS-1:0]     active_r, active_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic [SW-1:0]        ev_addr_r, ev_addr_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic [SW-1:0]        srch_r, srch_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [15:0]          hdl_r, hdl_nxt;
  res_t                 res_r, res_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 mem_we;
  logic [SW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_wdata;
  logic [SW-1:0]        rd_addr;
  logic [MW-1:0]        rd_data;

  logic [TICK_BITS-1:0] rd_start;
  logic [15:0]          rd_per;
  logic [15:0]          rd_hdl;
  logic                 ev_due;
  tl_t                  ev_tl;
  logic [TICK_BITS-1:0] ev_start_adv;

  logic [31:0]          grp_word;
  logic [SW-1:0]        id_addr;
  logic                 id_bad;
  logic [SW-1:0]        found;

  // slot table: {handle, period, start}
  ptd_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_start = rd_data[TICK_BITS-1:0];
  assign rd_per   = rd_data[TICK_BITS+15:TICK_BITS];
  assign rd_hdl   = rd_data[TICK_BITS+31:TICK_BITS+16];

  // shared slot evaluation for scan and dispatch
  ptd_slot_eval #(
    .TICK_BITS (TICK_BITS)
  ) u_eval (
    .tick      (tick_r),
    .start     (rd_start),
    .period    (rd_per),
    .due       (ev_due),
    .tl        (ev_tl),
    .start_adv (ev_start_adv)
  );

  // decode helpers
  assign id_bad   = int'(in_task_id) >= SLOTS;
  assign id_addr  = SW'(in_task_id);
  assign grp_word = active_r[srch_r +: GROUP_BITS];
  assign found    = srch_r + SW'(lsb32(grp_word));

  assign in_ready = state_r == S_IDLE;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    enabled_nxt   = enabled_r;
    active_nxt    = active_r;
    scan_nxt      = scan_r;
    ev_addr_nxt   = ev_addr_r;
    ev_vld_nxt    = ev_vld_r;
    iss_done_nxt  = iss_done_r;
    srch_nxt      = srch_r;
    slot_nxt      = slot_r;
    hdl_nxt       = hdl_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = rd_data;
    rd_addr       = slot_r;

    // output register drains
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          slot_nxt  = id_addr;
          hdl_nxt   = in_task_handle;
          state_nxt = S_DONE;
          unique case (mode_t'(in_mode))
            MODE_TICK: begin
              tick_nxt = tick_r + TICK_BITS'(1);
            end
            MODE_RUN: begin
              unique case (phase_r)
                PH_INIT: begin
                  res_nxt.phase_done = PD_INIT;
                  phase_nxt          = PH_SCAN;
                end
                PH_DISPATCH: begin
                  res_nxt.phase_done = PD_DISPATCH;
                  phase_nxt          = PH_SCAN;
                  srch_nxt           = '0;
                  state_nxt          = S_SRCH;
                end
                default: begin
                  res_nxt.phase_done = PD_SCAN;
                  phase_nxt          = PH_DISPATCH;
                  scan_nxt           = '0;
                  ev_vld_nxt         = 1'b0;
                  iss_done_nxt       = 1'b0;
                  state_nxt          = S_SCAN;
                end
              endcase
            end
            MODE_ADD: begin
              if (id_bad) begin
                res_nxt.status = STAT_RANGE;
              end else if (enabled_r[id_addr]) begin
                res_nxt.status = STAT_EXISTS;
              end else begin
                enabled_nxt[id_addr] = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = id_addr;
                mem_wdata = {in_task_handle, in_period_ticks, TICK_BITS'(in_start_tick)};
              end
            end
            MODE_DELETE: begin
              if (id_bad) begin
                res_nxt.status = STAT_RANGE;
              end else if (!enabled_r[id_addr]) begin
                res_nxt.status = STAT_NO_TASK;
              end else begin
                rd_addr   = id_addr;
                state_nxt = S_DEL;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one slot read per cycle
        rd_addr = scan_r;
        if (!iss_done_r) begin
          ev_vld_nxt  = 1'b1;
          ev_addr_nxt = scan_r;
          if (scan_r == SW'(SLOTS - 1)) begin
            iss_done_nxt = 1'b1;
          end else begin
            scan_nxt = scan_r + SW'(1);
          end
        end else begin
          ev_vld_nxt = 1'b0;
        end
        // evaluate the slot read last cycle; if due, activate, write back start
        if (ev_vld_r && enabled_r[ev_addr_r] && ev_due) begin
          active_nxt[ev_addr_r] = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = ev_addr_r;
          mem_wdata = {rd_hdl, rd_per, ev_start_adv};
        end
        if (iss_done_r && ev_vld_r) begin
          state_nxt = S_DONE;
        end
      end

      S_SRCH: begin
        // one group of active bits per cycle
        if (grp_word != '0) begin
          slot_nxt  = found;
          rd_addr   = found;
          state_nxt = S_DISP;
        end else if (srch_r == SW'(SLOTS - GROUP_BITS)) begin
          state_nxt = S_DONE;
        end else begin
          srch_nxt = srch_r + SW'(GROUP_BITS);
        end
      end

      S_DISP: begin
        active_nxt[slot_r] = 1'b0;
        if (rd_per == 16'd0) begin
          enabled_nxt[slot_r] = 1'b0;
        end
        if (ev_due) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = {rd_hdl, rd_per, ev_start_adv};
        end
        res_nxt.dispatched = 1'b1;
        res_nxt.id         = ID_BITS'(slot_r);
        res_nxt.handle     = rd_hdl;
        res_nxt.tl         = ev_tl;
        state_nxt          = S_DONE;
      end

      S_DEL: begin
        if (rd_hdl != hdl_r) begin
          res_nxt.status = STAT_MISMATCH;
        end else begin
          enabled_nxt[slot_r] = 1'b0;
          active_nxt[slot_r]  = 1'b0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_INIT;
      tick_r      <= '0;
      enabled_r   <= '0;
      active_r    <= '0;
      ev_vld_r    <= 1'b0;
      iss_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      enabled_r   <= enabled_nxt;
      active_r    <= active_nxt;
      ev_vld_r    <= ev_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    ev_addr_r <= ev_addr_nxt;
    srch_r    <= srch_nxt;
    slot_r    <= slot_nxt;
    hdl_r     <= hdl_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_phase_done        = out_r.phase_done;
  assign out_dispatched        = out_r.dispatched;
  assign out_dispatched_id     = out_r.id;
  assign out_dispatched_handle = out_r.handle;
  assign out_timeliness        = out_r.tl;

endmodule

[rtl/core/ptd_checker.sv]
// port-level checks of the periodic task dispatcher and their bind
module ptd_checker
  import ptd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [1:0]  out_phase_done,
  input logic        out_dispatched,
  input logic [5:0]  out_dispatched_id,
  input logic [15:0] out_dispatched_handle,
  input logic [1:0]  out_timeliness
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_phase_done) && $stable(out_dispatched) &&
    $stable(out_dispatched_id) && $stable(out_dispatched_handle) &&
    $stable(out_timeliness))
    else $error("result beat changed while stalled");

  // one item in work: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // no dispatch means empty dispatch fields
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dispatched |->
    out_dispatched_id == 6'd0 && out_dispatched_handle == 16'd0 &&
    out_timeliness == TL_ON_TIME)
    else $error("dispatch fields set without a dispatch");

  // a dispatch only comes from a dispatch step
  a_dispatch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dispatched |->
    out_phase_done == PD_DISPATCH && out_status == STAT_OK)
    else $error("dispatch outside a dispatch step");

  // run steps never report an edit status
  a_run_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase_done != PD_NONE |-> out_status == STAT_OK)
    else $error("run step with nonzero status");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_status            (out_status),
  .out_phase_done        (out_phase_done),
  .out_dispatched        (out_dispatched),
  .out_dispatched_id     (out_dispatched_id),
  .out_dispatched_handle (out_dispatched_handle),
  .out_timeliness        (out_timeliness)
);

[tb/periodic_task_dispatcher_test.sv]
// self-checking testbench for the periodic task dispatcher with its own scheduler predictor
`timescale 1ns / 1ps

module periodic_task_dispatcher_test;
  import ptd_pkg::*;

  localparam int GROUPS      = 2;
  localparam int TICK_BITS   = 32;
  localparam int SLOT_COUNT  = GROUPS * 32;
  localparam int ITEM_COUNT  = 1700;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 40;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    mode_t       mode;
    logic [7:0]  id;
    logic [15:0] hdl;
    logic [15:0] per;
    logic [15:0] st;
  } sched_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = 2'd0;
  logic [7:0]  in_task_id = 8'd0;
  logic [15:0] in_task_handle = 16'd0;
  logic [15:0] in_period_ticks = 16'd0;
  logic [15:0] in_start_tick = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_phase_done;
  logic        out_dispatched;
  logic [5:0]  out_dispatched_id;
  logic [15:0] out_dispatched_handle;
  logic [1:0]  out_timeliness;

  periodic_task_dispatcher #(
    .GROUPS   (GROUPS),
    .TICK_BITS(TICK_BITS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_task_id           (in_task_id),
    .in_task_handle       (in_task_handle),
    .in_period_ticks      (in_period_ticks),
    .in_start_tick        (in_start_tick),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_phase_done       (out_phase_done),
    .out_dispatched       (out_dispatched),
    .out_dispatched_id    (out_dispatched_id),
    .out_dispatched_handle(out_dispatched_handle),
    .out_timeliness       (out_timeliness)
  );

  always #5 clk = ~clk;

  // scheduler shadow state
  logic [31:0] sched_tick;
  phase_t      sched_phase;
  logic        slot_en    [SLOT_COUNT];
  logic        slot_act   [SLOT_COUNT];
  logic [15:0] slot_per   [SLOT_COUNT];
  logic [31:0] slot_start [SLOT_COUNT];
  logic [15:0] slot_hdl   [SLOT_COUNT];

  sched_item_t pending_items[$];
  res_t        due_results[$];
  res_t        sched_want;

  int n_accepted = 0;
  int results_seen = 0;
  int err_count = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // generator-side view of the table, only used to aim deletes
  int          gen_tick;
  bit          gen_used [SLOT_COUNT];
  logic [15:0] gen_hdl  [SLOT_COUNT];

  // advance the shadow scheduler by one beat and return the expected result
  function automatic res_t schedule_step(input mode_t m, input logic [7:0] id,
                                         input logic [15:0] hdl, input logic [15:0] per,
                                         input logic [15:0] st);
    res_t        r;
    int          s;
    logic [31:0] el;
    r = '0;
    if (m == MODE_TICK) begin
      sched_tick = sched_tick + 32'd1;
    end else if (m == MODE_RUN) begin
      case (sched_phase)
        PH_INIT: begin
          r.phase_done = PD_INIT;
          sched_phase  = PH_SCAN;
        end
        PH_DISPATCH: begin
          r.phase_done = PD_DISPATCH;
          // lowest active slot wins
          for (s = 0; s < SLOT_COUNT; s++) begin
            if (slot_act[s] && !r.dispatched) begin
              r.dispatched = 1'b1;
              r.id         = 6'(s);
              r.handle     = slot_hdl[s];
              slot_act[s]  = 1'b0;
              if (slot_per[s] == 16'd0) slot_en[s] = 1'b0;
              el = sched_tick - slot_start[s];
              if (el >= {16'd0, slot_per[s]}) begin
                r.tl          = TL_MISSED;
                slot_start[s] = slot_start[s] + {16'd0, slot_per[s]};
              end else if (el >= {17'd0, slot_per[s][15:1]}) begin
                r.tl = TL_DELAYED;
              end
            end
          end
          sched_phase = PH_SCAN;
        end
        default: begin
          // activation scan over every enabled slot
          r.phase_done = PD_SCAN;
          for (s = 0; s < SLOT_COUNT; s++) begin
            if (slot_en[s] && (sched_tick - slot_start[s]) >= {16'd0, slot_per[s]}) begin
              slot_act[s]   = 1'b1;
              slot_start[s] = slot_start[s] + {16'd0, slot_per[s]};
            end
          end
          sched_phase = PH_DISPATCH;
        end
      endcase
    end else if (id >= SLOT_COUNT) begin
      r.status = STAT_RANGE;
    end else if (m == MODE_ADD) begin
      if (slot_en[id]) begin
        r.status = STAT_EXISTS;
      end else begin
        slot_en[id]    = 1'b1;
        slot_hdl[id]   = hdl;
        slot_per[id]   = per;
        slot_start[id] = {16'd0, st};
      end
    end else begin
      if (!slot_en[id]) begin
        r.status = STAT_NO_TASK;
      end else if (slot_hdl[id] != hdl) begin
        r.status = STAT_MISMATCH;
      end else begin
        slot_en[id]    = 1'b0;
        slot_act[id]   = 1'b0;
        slot_hdl[id]   = 16'd0;
        slot_per[id]   = 16'd0;
        slot_start[id] = 32'd0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("ERROR: result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
  endtask

  task automatic queue_item(input mode_t m, input logic [7:0] id, input logic [15:0] hdl,
                            input logic [15:0] per, input logic [15:0] st);
    sched_item_t it;
    it.mode = m;
    it.id   = id;
    it.hdl  = hdl;
    it.per  = per;
    it.st   = st;
    pending_items.push_back(it);
    if (m == MODE_TICK) gen_tick++;
  endtask

  // random 16-bit value: filler for fields a beat ignores, and random handles, periods, starts
  function automatic logic [15:0] noise16();
    return 16'($urandom);
  endfunction

  // driver: offers one beat at a time, predicts each accepted beat
  always @(posedge clk) begin
    sched_item_t it;
    bit          quiet;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(schedule_step(mode_t'(in_mode), in_task_id, in_task_handle,
                                            in_period_ticks, in_start_tick));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        quiet = (pending_items.size() < QUIET_TAIL) || ((n_accepted / 128) % 4 == 3);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_mode         <= it.mode;
          in_task_id      <= it.id;
          in_task_handle  <= it.hdl;
          in_period_ticks <= it.per;
          in_start_tick   <= it.st;
          in_valid        <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    bit quiet;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("beat with nothing pending, status", out_status, 0);
        end else begin
          sched_want = due_results.pop_front();
          if (out_status !== sched_want.status)
            report_mismatch("status", out_status, sched_want.status);
          if (out_phase_done !== sched_want.phase_done)
            report_mismatch("phase_done", out_phase_done, sched_want.phase_done);
          if (out_dispatched !== sched_want.dispatched)
            report_mismatch("dispatched", out_dispatched, sched_want.dispatched);
          if (out_dispatched_id !== sched_want.id)
            report_mismatch("dispatched_id", out_dispatched_id, sched_want.id);
          if (out_dispatched_handle !== sched_want.handle)
            report_mismatch("dispatched_handle", out_dispatched_handle, sched_want.handle);
          if (out_timeliness !== sched_want.tl)
            report_mismatch("timeliness", out_timeliness, sched_want.tl);
        end
        results_seen <= results_seen + 1;
      end
      quiet = (results_seen > ITEM_COUNT - QUIET_TAIL) || ((results_seen / 100) % 4 == 1);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          pick;
    int          id;
    logic [15:0] h;
    logic [15:0] per;
    logic [15:0] st;

    // shadow reset
    sched_tick  = 32'd0;
    sched_phase = PH_INIT;
    gen_tick    = 0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_en[s]    = 1'b0;
      slot_act[s]   = 1'b0;
      slot_per[s]   = 16'd0;
      slot_start[s] = 32'd0;
      slot_hdl[s]   = 16'd0;
      gen_used[s]   = 1'b0;
      gen_hdl[s]    = 16'd0;
    end

    // directed: empty scan and dispatch, table edits and their errors
    queue_item(MODE_RUN, 8'($urandom), noise16(), noise16(), noise16());
    queue_item(MODE_RUN, 8'($urandom), noise16(), noise16(), noise16());
    queue_item(MODE_RUN, 8'($urandom), noise16(), noise16(), noise16());
    queue_item(MODE_ADD, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    queue_item(MODE_ADD, 8'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(MODE_ADD, 8'd32, 16'h1234, 16'd3, 16'h0000);
    queue_item(MODE_ADD, 8'd64, 16'h5555, 16'd1, 16'd0);
    queue_item(MODE_ADD, 8'd255, 16'hAAAA, 16'd1, 16'd0);
    queue_item(MODE_DELETE, 8'd200, 16'h0000, 16'd0, 16'd0);
    queue_item(MODE_ADD, 8'd0, 16'h0001, 16'd5, 16'd0);
    queue_item(MODE_DELETE, 8'd5, 16'h0000, 16'd0, 16'd0);
    queue_item(MODE_DELETE, 8'd63, 16'h0000, 16'd0, 16'd0);
    repeat (4) queue_item(MODE_TICK, 8'($urandom), noise16(), noise16(), noise16());
    // one-shot slot dispatched as missed, then delayed, then wrapped start missed
    repeat (6) queue_item(MODE_RUN, 8'($urandom), noise16(), noise16(), noise16());
    queue_item(MODE_DELETE, 8'd63, 16'hFFFF, 16'd0, 16'd0);
    queue_item(MODE_DELETE, 8'd32, 16'h1234, 16'd0, 16'd0);
    queue_item(MODE_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // random traffic, mostly small periods and starts near the current tick
    while (pending_items.size() < ITEM_COUNT) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) id = $urandom_range(0, 15);
      else if (pick < 45) id = $urandom_range(0, SLOT_COUNT - 1);
      else if (pick < 55) id = $urandom_range(SLOT_COUNT, 255);
      else id = $urandom_range(0, 15);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_item(MODE_TICK, 8'($urandom), noise16(), noise16(), noise16());
      end else if (pick < 70) begin
        queue_item(MODE_RUN, 8'($urandom), noise16(), noise16(), noise16());
      end else if (pick < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) per = 16'($urandom_range(1, 12));
        else if (pick < 75) per = 16'd0;
        else if (pick < 90) per = 16'($urandom_range(13, 200));
        else per = noise16();
        if ($urandom_range(0, 9) < 7) st = 16'(gen_tick - $urandom_range(0, 3));
        else st = noise16();
        pick = $urandom_range(0, 9);
        h = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : noise16();
        if (id < SLOT_COUNT && !gen_used[id]) begin
          gen_used[id] = 1'b1;
          gen_hdl[id]  = h;
        end
        queue_item(MODE_ADD, 8'(id), h, per, st);
      end else begin
        if (id < SLOT_COUNT && $urandom_range(0, 3) != 0) begin
          h = gen_hdl[id];
          gen_used[id] = 1'b0;
        end else begin
          h = noise16();
        end
        queue_item(MODE_DELETE, 8'(id), h, noise16(), noise16());
      end
    end

    // reset, then wait for all beats to go through
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < ITEM_COUNT || due_results.size() != 0) @(posedge clk);
    repeat (4 * SLOT_COUNT) @(posedge clk);

    if (err_count == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ptd_pkg.sv
rtl/core/ptd_ram.sv
rtl/core/ptd_slot_eval.sv
rtl/core/periodic_task_dispatcher.sv
rtl/core/ptd_checker.sv
tb/periodic_task_dispatcher_test.sv
